// ===== hw/rtl/pru_pkg.sv =====
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the pixel replicating upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package pru_pkg;

  // Line buffer depth default
  localparam int unsigned DefaultMaxWidth = 2048;

  // Scale factor saturation limit
  localparam logic [6:0] FactorLimit = 7'd99;

  // Output rows are padded to a multiple of this many bytes
  localparam int unsigned RowAlign = 4;

  // Value carried by pad bytes
  localparam logic [7:0] PadByte = 8'h00;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgScaleFactor = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInputWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInputHeight = 2'd2;

  localparam logic [6:0]  ScaleFactorRst = 7'd1;
  localparam logic [11:0] InputWidthRst  = 12'd1;
  localparam logic [15:0] InputHeightRst = 16'd1;

  // Operation codes
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_word_t;

  typedef struct packed {
    logic       is_pad;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;
    logic       image_end;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pru_ram.sv =====
// ----------------------------------------------------------------------------
// pru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pru_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pixel_replicating_upscaler.sv =====
// ----------------------------------------------------------------------------
// pixel_replicating_upscaler
// Integer nearest-neighbor upscaler for 24-bit BGR pixel rows.
// ----------------------------------------------------------------------------
// Load words (operation = load) fill the line buffer with one input scanline
// of input_width pixels. Once the scanline is complete the block switches to
// emitting: every tick word then yields one output word. Each pixel is
// repeated scale_factor times across, followed by zero pad bytes (one word
// each, is_pad set) that bring the row to a multiple of 4 bytes. The row is
// emitted scale_factor times, then the next scanline is loaded. row_end marks
// the last word of each output row, image_end the last of the image, after
// which the block loads the first scanline of the next image. Load words
// while emitting and ticks while loading are taken and produce nothing.
// Scale factor 0 acts as 1 and values above 99 saturate at 99; width and
// height 0 act as 1, width saturates at MAX_WIDTH.
// Rate: one input word per clock, sustained while out_stall_i stays low, with
// no bubbles between rows or images. A tick's pixel is captured by the line
// buffer's registered read port at the accepting edge and is then taken into
// the output register once that register can load. The output register plus
// the read stage let a new word be taken while a finished word still waits
// on out_stall_i. No reset-time clearing pass: buffer entries are only read
// after being loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_replicating_upscaler #(
  parameter int unsigned MAX_WIDTH = pru_pkg::DefaultMaxWidth
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire pru_pkg::in_word_t            in_word_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output pru_pkg::out_word_t                out_word_o,
  // configuration
  input  wire logic                         cfg_we_i,
  input  wire logic [pru_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [pru_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // widest usable scanline: register is 12 bits
  localparam int unsigned WidthCap = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;

  // ---------------- configuration registers ----------------
  logic [6:0]  scale_factor_q;
  logic [11:0] input_width_q;
  logic [15:0] input_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_factor_q <= pru_pkg::ScaleFactorRst;
      input_width_q  <= pru_pkg::InputWidthRst;
      input_height_q <= pru_pkg::InputHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pru_pkg::CfgScaleFactor: scale_factor_q <= cfg_data_i[6:0];
        pru_pkg::CfgInputWidth:  input_width_q  <= cfg_data_i[11:0];
        pru_pkg::CfgInputHeight: input_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective values
  logic [6:0]  eff_f;
  logic [11:0] eff_w;
  logic [15:0] eff_h;
  logic [1:0]  pad_total;

  always_comb begin
    if (scale_factor_q == 7'd0) begin
      eff_f = 7'd1;
    end else if (scale_factor_q > pru_pkg::FactorLimit) begin
      eff_f = pru_pkg::FactorLimit;
    end else begin
      eff_f = scale_factor_q;
    end
    if (input_width_q == 12'd0) begin
      eff_w = 12'd1;
    end else if (input_width_q > 12'(WidthCap)) begin
      eff_w = 12'(WidthCap);
    end else begin
      eff_w = input_width_q;
    end
    eff_h = (input_height_q == 16'd0) ? 16'd1 : input_height_q;
  end

  // Row bytes = 3*W*F. Pad = -(3*W*F) mod 4 = (W*F) mod 4, since 3 = -1 mod 4.
  assign pad_total = 2'(eff_w[1:0] * eff_f[1:0]);

  // ---------------- sequencer state ----------------
  logic [11:0] fill_index_q,   fill_index_d;
  logic [11:0] read_column_q,  read_column_d;
  logic [6:0]  across_count_q, across_count_d;
  logic [6:0]  down_count_q,   down_count_d;
  logic [1:0]  pad_count_q,    pad_count_d;
  logic [15:0] row_count_q,    row_count_d;
  logic        emitting_q,     emitting_d;
  logic        pad_phase_q,    pad_phase_d;

  // read stage (line buffer data lands alongside)
  logic        s1_valid_q, s1_valid_d;
  logic        s1_pad_q,   s1_pad_d;
  logic        s1_rend_q,  s1_rend_d;
  logic        s1_iend_q,  s1_iend_d;

  logic        out_valid_q;
  pru_pkg::out_word_t out_word_q;

  logic        out_load;
  logic        in_accept;
  logic        is_tick;
  logic        wr_en;
  logic        rd_en;
  logic [23:0] rd_data;

  // output register takes a new word when empty or draining
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_tick    = (in_word_i.operation == pru_pkg::OpTick);

  logic [12:0] fill_next;
  logic [12:0] col_next;
  logic [7:0]  across_next;
  logic [7:0]  down_next;
  logic [2:0]  pad_next;
  logic [16:0] row_next;
  logic        row_done;

  assign fill_next   = {1'b0, fill_index_q} + 13'd1;
  assign col_next    = {1'b0, read_column_q} + 13'd1;
  assign across_next = {1'b0, across_count_q} + 8'd1;
  assign down_next   = {1'b0, down_count_q} + 8'd1;
  assign pad_next    = {1'b0, pad_count_q} + 3'd1;
  assign row_next    = {1'b0, row_count_q} + 17'd1;

  always_comb begin
    fill_index_d   = fill_index_q;
    read_column_d  = read_column_q;
    across_count_d = across_count_q;
    down_count_d   = down_count_q;
    pad_count_d    = pad_count_q;
    row_count_d    = row_count_q;
    emitting_d     = emitting_q;
    pad_phase_d    = pad_phase_q;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    row_done       = 1'b0;
    s1_pad_d       = s1_pad_q;
    s1_rend_d      = s1_rend_q;
    s1_iend_d      = s1_iend_q;
    s1_valid_d     = s1_valid_q && !out_load;

    if (in_accept) begin
      s1_valid_d = is_tick && emitting_q;
      if (!is_tick && !emitting_q) begin
        // load one pixel
        wr_en        = 1'b1;
        fill_index_d = fill_next[11:0];
        if (fill_next >= {1'b0, eff_w}) begin
          fill_index_d   = 12'd0;
          emitting_d     = 1'b1;
          read_column_d  = 12'd0;
          across_count_d = 7'd0;
          down_count_d   = 7'd0;
          pad_count_d    = 2'd0;
          pad_phase_d    = 1'b0;
        end
      end else if (is_tick && emitting_q) begin
        s1_rend_d = 1'b0;
        s1_iend_d = 1'b0;
        if (!pad_phase_q) begin
          // pixel element
          s1_pad_d       = 1'b0;
          rd_en          = 1'b1;
          across_count_d = across_next[6:0];
          if (across_next >= {1'b0, eff_f}) begin
            across_count_d = 7'd0;
            if (col_next >= {1'b0, eff_w}) begin
              if (pad_total != 2'd0) begin
                pad_phase_d = 1'b1;
                pad_count_d = 2'd0;
              end else begin
                row_done = 1'b1;
              end
            end else begin
              read_column_d = col_next[11:0];
            end
          end
        end else begin
          // pad byte
          s1_pad_d    = 1'b1;
          pad_count_d = pad_next[1:0];
          if (pad_next >= {1'b0, pad_total}) begin
            row_done = 1'b1;
          end
        end

        if (row_done) begin
          s1_rend_d      = 1'b1;
          read_column_d  = 12'd0;
          across_count_d = 7'd0;
          pad_count_d    = 2'd0;
          pad_phase_d    = 1'b0;
          down_count_d   = down_next[6:0];
          if (down_next >= {1'b0, eff_f}) begin
            // scanline fully replicated: back to loading
            down_count_d = 7'd0;
            emitting_d   = 1'b0;
            fill_index_d = 12'd0;
            if (row_next >= {1'b0, eff_h}) begin
              row_count_d = 16'd0;
              s1_iend_d   = 1'b1;
            end else begin
              row_count_d = row_next[15:0];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_index_q   <= 12'd0;
      read_column_q  <= 12'd0;
      across_count_q <= 7'd0;
      down_count_q   <= 7'd0;
      pad_count_q    <= 2'd0;
      row_count_q    <= 16'd0;
      emitting_q     <= 1'b0;
      pad_phase_q    <= 1'b0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      fill_index_q   <= fill_index_d;
      read_column_q  <= read_column_d;
      across_count_q <= across_count_d;
      down_count_q   <= down_count_d;
      pad_count_q    <= pad_count_d;
      row_count_q    <= row_count_d;
      emitting_q     <= emitting_d;
      pad_phase_q    <= pad_phase_d;
      s1_valid_q     <= s1_valid_d;
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // read stage flags: payload only, no reset
  always_ff @(posedge clk_i) begin
    s1_pad_q  <= s1_pad_d;
    s1_rend_q <= s1_rend_d;
    s1_iend_q <= s1_iend_d;
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_word_q.is_pad    <= s1_pad_q;
      out_word_q.blue_out  <= s1_pad_q ? pru_pkg::PadByte : rd_data[7:0];
      out_word_q.green_out <= s1_pad_q ? pru_pkg::PadByte : rd_data[15:8];
      out_word_q.red_out   <= s1_pad_q ? pru_pkg::PadByte : rd_data[23:16];
      out_word_q.row_end   <= s1_rend_q;
      out_word_q.image_end <= s1_iend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // ---------------- line buffer ----------------
  // Read data only changes on a tick accept, which waits for the read stage
  // to drain, so it holds while the read stage is stalled.
  pru_ram #(
    .Width (24),
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (AddrW'(fill_index_q)),
    .wdata_i ({in_word_i.red_in, in_word_i.green_in, in_word_i.blue_in}),
    .re_i    (rd_en),
    .raddr_i (AddrW'(read_column_q)),
    .rdata_o (rd_data)
  );

endmodule

`default_nettype wire
